// ===== design/wmns_pkg.sv =====
// Shared types and constants for the windowed median neighborhood sum block.
package wmns_pkg;

    localparam int DEPTH = 64;
    localparam int HALF  = 2;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam int KEY_W  = 32;
    localparam int SUM_W  = 35;
    localparam int CNT_W  = 3;
    localparam int WORD_W = 2 * KEY_W;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic clear;
        logic step;
    } t_rank_ctl;

endpackage

// ===== design/wmns_ram.sv =====
// Single-port-write, registered-read sample memory.
module wmns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/wmns_rank_unit.sv =====
// Shared comparator and rank counter: counts stored samples ordered before the key.
module wmns_rank_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wmns_pkg::t_rank_ctl       i_ctl,
    input  logic [wmns_pkg::KEY_W-1:0] i_key_size,
    input  logic [wmns_pkg::AW-1:0]    i_key_slot,
    input  logic [wmns_pkg::KEY_W-1:0] i_cand_size,
    input  logic [wmns_pkg::AW-1:0]    i_cand_slot,
    output logic [wmns_pkg::CW-1:0]    o_rank
);
    import wmns_pkg::*;

    logic [CW-1:0] r_rank;
    logic [CW-1:0] n_rank;
    logic          before_key;

    assign before_key = (i_cand_size < i_key_size) ||
                        ((i_cand_size == i_key_size) && (i_cand_slot < i_key_slot));

    always_comb begin
        n_rank = r_rank;
        if (i_ctl.clear) begin
            n_rank = '0;
        end else if (i_ctl.step && before_key) begin
            n_rank = r_rank + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else begin
            r_rank <= n_rank;
        end
    end

    assign o_rank = r_rank;
endmodule

// ===== design/windowed_median_neighborhood_sum.sv =====
// Top level: sample ring, query sequencer, window sums and output register.
// Add: taken while idle, no result word. A query over n stored samples is run by one
// shared comparator that ranks each sample against all others, one memory read per
// cycle; an empty store skips the scan and answers directly.
// Input stall is high while a query runs; a pending result word does not block adds.
// Synchronous active-low reset clears pointers, fill count and output valid, not the memory.
module windowed_median_neighborhood_sum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [wmns_pkg::KEY_W-1:0]    i_sample_files,
    input  logic [wmns_pkg::KEY_W-1:0]    i_sample_size,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [wmns_pkg::SUM_W-1:0]    o_size_sum,
    output logic [wmns_pkg::SUM_W-1:0]    o_files_sum,
    output logic [wmns_pkg::CNT_W-1:0]    o_summed_count
);
    import wmns_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD_I = 6'b000010,
        S_LD_I = 6'b000100,
        S_SCAN = 6'b001000,
        S_CHK  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_wslot, n_wslot;
    logic [CW-1:0]   r_filled, n_filled;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_low, n_low;
    logic [CW-1:0]   r_high, n_high;
    logic [AW-1:0]   r_i, n_i;
    logic [AW-1:0]   r_jd, n_jd;
    logic [KEY_W-1:0] r_key_size, n_key_size;
    logic [KEY_W-1:0] r_key_files, n_key_files;
    logic [SUM_W-1:0] r_ssum, n_ssum;
    logic [SUM_W-1:0] r_fsum, n_fsum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [SUM_W-1:0] r_out_size, n_out_size;
    logic [SUM_W-1:0] r_out_files, n_out_files;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;

    logic              in_take;
    logic              mem_we;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;
    t_rank_ctl         rank_ctl;
    logic [CW-1:0]     rank;
    logic [CW-1:0]     mid;
    logic [CW:0]       top_rank;
    logic [CW-1:0]     last_rank;

    assign o_stall = (r_state != S_IDLE);
    assign in_take = i_valid && !o_stall;
    assign mem_we  = in_take && (i_opcode == OP_ADD);

    assign mid       = r_filled >> 1;
    assign last_rank = r_filled - CW'(1);
    assign top_rank  = {1'b0, mid} + (CW + 1)'(HALF);

    wmns_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wslot),
        .i_wdata ({i_sample_size, i_sample_files}),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    wmns_rank_unit u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (rank_ctl),
        .i_key_size  (r_key_size),
        .i_key_slot  (r_i),
        .i_cand_size (mem_rdata[WORD_W-1:KEY_W]),
        .i_cand_slot (r_jd),
        .o_rank      (rank)
    );

    always_comb begin
        n_state     = r_state;
        n_wslot     = r_wslot;
        n_filled    = r_filled;
        n_n         = r_n;
        n_low       = r_low;
        n_high      = r_high;
        n_i         = r_i;
        n_jd        = r_jd;
        n_key_size  = r_key_size;
        n_key_files = r_key_files;
        n_ssum      = r_ssum;
        n_fsum      = r_fsum;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_out_size  = r_out_size;
        n_out_files = r_out_files;
        n_out_cnt   = r_out_cnt;
        mem_raddr   = r_i;
        rank_ctl    = '{clear: 1'b0, step: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (in_take && (i_opcode == OP_ADD)) begin
                    n_wslot = (r_wslot == AW'(DEPTH - 1)) ? '0 : r_wslot + AW'(1);
                    if (r_filled != CW'(DEPTH)) begin
                        n_filled = r_filled + CW'(1);
                    end
                end else if (in_take) begin
                    n_n    = r_filled;
                    n_low  = (mid >= CW'(HALF)) ? mid - CW'(HALF) : '0;
                    n_high = (top_rank > {1'b0, last_rank}) ? last_rank : top_rank[CW-1:0];
                    n_i    = '0;
                    n_ssum = '0;
                    n_fsum = '0;
                    n_cnt  = '0;
                    n_state = (r_filled == '0) ? S_DONE : S_RD_I;
                end
            end
            S_RD_I: begin
                mem_raddr = r_i;
                n_state   = S_LD_I;
            end
            S_LD_I: begin
                n_key_size  = mem_rdata[WORD_W-1:KEY_W];
                n_key_files = mem_rdata[KEY_W-1:0];
                rank_ctl    = '{clear: 1'b1, step: 1'b0};
                mem_raddr   = '0;
                n_jd        = '0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                rank_ctl  = '{clear: 1'b0, step: 1'b1};
                mem_raddr = r_jd + AW'(1);
                if (CW'(r_jd) == r_n - CW'(1)) begin
                    n_state = S_CHK;
                end else begin
                    n_jd = r_jd + AW'(1);
                end
            end
            S_CHK: begin
                if ((rank >= r_low) && (rank <= r_high)) begin
                    n_ssum = r_ssum + SUM_W'(r_key_size);
                    n_fsum = r_fsum + SUM_W'(r_key_files);
                    n_cnt  = r_cnt + CNT_W'(1);
                end
                if (CW'(r_i) == r_n - CW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_RD_I;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_size  = r_ssum;
                    n_out_files = r_fsum;
                    n_out_cnt   = r_cnt;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wslot     <= '0;
            r_filled    <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_jd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wslot     <= n_wslot;
            r_filled    <= n_filled;
            r_n         <= n_n;
            r_i         <= n_i;
            r_jd        <= n_jd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low       <= n_low;
        r_high      <= n_high;
        r_key_size  <= n_key_size;
        r_key_files <= n_key_files;
        r_ssum      <= n_ssum;
        r_fsum      <= n_fsum;
        r_cnt       <= n_cnt;
        r_out_size  <= n_out_size;
        r_out_files <= n_out_files;
        r_out_cnt   <= n_out_cnt;
    end

    assign o_valid        = r_out_valid;
    assign o_size_sum     = r_out_size;
    assign o_files_sum    = r_out_files;
    assign o_summed_count = r_out_cnt;

`ifndef SYNTHESIS
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CW'(DEPTH))
        else $error("fill count above ring depth");

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (rank < r_n))
        else $error("rank outside stored samples");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((CW'(r_jd) < r_n) && (CW'(r_i) < r_n)))
        else $error("scan slot beyond stored samples");
`endif
endmodule

// ===== sim/windowed_median_neighborhood_sum_tb.sv =====
// Self-checking testbench: sample adds and median-window sum queries against a predictor.
module windowed_median_neighborhood_sum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wmns_pkg::*;

    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int RANDOM_WORDS = 900;
    localparam int CHUNK_WORDS  = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef struct {
        logic [SUM_W-1:0] size_sum;
        logic [SUM_W-1:0] files_sum;
        logic [CNT_W-1:0] count;
    } t_window_sums;

    class median_window_scoreboard;
        logic [KEY_W-1:0] sizes [DEPTH];
        logic [KEY_W-1:0] files [DEPTH];
        int write_slot;
        int filled;
        int errors;
        t_window_sums expected_sums [$];

        function new();
            write_slot = 0;
            filled     = 0;
            errors     = 0;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function t_window_sums window_sums();
            t_window_sums s;
            logic [63:0] ssum;
            logic [63:0] fsum;
            int mid, lo, hi, rank, cnt;
            ssum = '0;
            fsum = '0;
            cnt  = 0;
            if (filled > 0) begin
                mid = filled / 2;
                lo  = (mid >= HALF) ? mid - HALF : 0;
                hi  = (mid + HALF > filled - 1) ? filled - 1 : mid + HALF;
                for (int i = 0; i < filled; i++) begin
                    rank = 0;
                    for (int j = 0; j < filled; j++) begin
                        if (sizes[j] < sizes[i] || (sizes[j] == sizes[i] && j < i)) begin
                            rank++;
                        end
                    end
                    if (rank >= lo && rank <= hi) begin
                        ssum += sizes[i];
                        fsum += files[i];
                        cnt++;
                    end
                end
            end
            s.size_sum  = ssum[SUM_W-1:0];
            s.files_sum = fsum[SUM_W-1:0];
            s.count     = cnt[CNT_W-1:0];
            return s;
        endfunction

        function void note_word(logic op, logic [KEY_W-1:0] f, logic [KEY_W-1:0] s);
            if (op == OP_ADD) begin
                files[write_slot] = f;
                sizes[write_slot] = s;
                write_slot = (write_slot + 1) % DEPTH;
                if (filled < DEPTH) begin
                    filled++;
                end
            end else begin
                expected_sums.push_back(window_sums());
            end
        endfunction

        task check_word(t_window_sums got);
            t_window_sums want;
            if (expected_sums.size() == 0) begin
                report($sformatf("unexpected result word size_sum=%0d files_sum=%0d count=%0d",
                                 got.size_sum, got.files_sum, got.count));
                return;
            end
            want = expected_sums.pop_front();
            if (got.size_sum !== want.size_sum) begin
                report($sformatf("size_sum got %0d expected %0d", got.size_sum, want.size_sum));
            end
            if (got.files_sum !== want.files_sum) begin
                report($sformatf("files_sum got %0d expected %0d", got.files_sum, want.files_sum));
            end
            if (got.count !== want.count) begin
                report($sformatf("summed_count got %0d expected %0d", got.count, want.count));
            end
        endtask

        task check_drained();
            if (expected_sums.size() > 0) begin
                report($sformatf("%0d result words never arrived", expected_sums.size()));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_opcode;
    logic [KEY_W-1:0]   i_sample_files;
    logic [KEY_W-1:0]   i_sample_size;
    logic               o_valid;
    logic               i_stall;
    logic [SUM_W-1:0]   o_size_sum;
    logic [SUM_W-1:0]   o_files_sum;
    logic [CNT_W-1:0]   o_summed_count;

    median_window_scoreboard sb = new();

    bit tx_idle_on;
    bit rx_idle_on;
    int stall_left = 0;
    int cycles     = 0;

    windowed_median_neighborhood_sum dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_sample_files (i_sample_files),
        .i_sample_size  (i_sample_size),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_size_sum     (o_size_sum),
        .o_files_sum    (o_files_sum),
        .o_summed_count (o_summed_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            i_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        t_window_sums got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.size_sum  = o_size_sum;
            got.files_sum = o_files_sum;
            got.count     = o_summed_count;
            sb.check_word(got);
        end
    end

    // Called and returns at a falling edge; holds the word until accepted.
    task automatic send_word(logic op, logic [KEY_W-1:0] f, logic [KEY_W-1:0] s);
        bit accepted;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_sample_files <= f;
        i_sample_size  <= s;
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = !o_stall;
            @(negedge i_clk);
        end
        sb.note_word(op, f, s);
    endtask

    function automatic logic [KEY_W-1:0] pick_size();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 7);
            2: return '0;
            3: return KEY_MAX;
            4: return KEY_MAX - $urandom_range(0, 3);
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_files();
        case ($urandom_range(0, 7))
            5: return '0;
            6: return KEY_MAX;
            7: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic op;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = OP_ADD;
        i_sample_files = '0;
        i_sample_size  = '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(OP_QUERY, KEY_MAX, KEY_MAX);
        send_word(OP_ADD, KEY_MAX, KEY_MAX);
        send_word(OP_QUERY, '0, '0);
        send_word(OP_ADD, KEY_MAX, KEY_MAX);
        send_word(OP_QUERY, '0, '0);
        repeat (3) send_word(OP_ADD, KEY_MAX, KEY_MAX);
        send_word(OP_QUERY, '0, '0);
        send_word(OP_ADD, '0, '0);
        send_word(OP_QUERY, '0, '0);
        for (int i = 0; i < 4; i++) begin
            send_word(OP_ADD, 100 + i, 7);
        end
        send_word(OP_QUERY, '0, '0);
        send_word(OP_ADD, 200, 7);
        send_word(OP_QUERY, '0, '0);

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k % CHUNK_WORDS == 0) begin
                tx_idle_on = (k < RANDOM_WORDS - CHUNK_WORDS) &&
                             ((k / CHUNK_WORDS) % 2 == 0 || $urandom_range(0, 1));
                rx_idle_on = (k < RANDOM_WORDS - CHUNK_WORDS) &&
                             ((k / CHUNK_WORDS) % 2 == 0 || $urandom_range(0, 1));
            end
            op = ($urandom_range(0, 10) == 0) ? OP_QUERY : OP_ADD;
            send_word(op, pick_files(), pick_size());
        end
        i_valid <= 1'b0;

        while (sb.expected_sums.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/wmns_pkg.sv
design/wmns_ram.sv
design/wmns_rank_unit.sv
design/windowed_median_neighborhood_sum.sv
sim/windowed_median_neighborhood_sum_tb.sv
